@@ rtl/fifo_with_prefix_reverse_core_assert.svh @@
// assertion macros for the prefix-reverse queue checker
// no dependencies; taken in by the checker file
`ifndef FIFO_WITH_PREFIX_REVERSE_CORE_ASSERT_SVH
`define FIFO_WITH_PREFIX_REVERSE_CORE_ASSERT_SVH

// checked on every edge outside reset
`define FWPR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FWPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/fwpr_pkg.sv @@
// shared constants, codes and types for the prefix-reverse queue
// no dependencies
`timescale 1ns / 1ps

package fwpr_pkg;

    // queue geometry
    localparam int DEPTH = 128;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    // request and result field widths
    localparam int FUNC_W = 2;
    localparam int WORD_W = 32;
    localparam int OCC_W  = 8;
    localparam int STAT_W = 2;

    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);

    // operation codes
    localparam logic [FUNC_W-1:0] FN_ENQ = 2'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ = 2'd1;
    localparam logic [FUNC_W-1:0] FN_REV = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // word returned by a dequeue from an empty queue
    localparam logic signed [WORD_W-1:0] POP_NONE = '1;

    // one access to the entry memory
    typedef struct packed {
        logic              we;
        logic [AW-1:0]     waddr;
        logic [WORD_W-1:0] wdata;
        logic [AW-1:0]     raddr;
    } ram_req_t;

endpackage

@@ rtl/fwpr_if.sv @@
// request and result channel interfaces of the prefix-reverse queue
// depends on fwpr_pkg
`timescale 1ns / 1ps

interface fwpr_cmd_if;
    import fwpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [WORD_W-1:0] push_value;
    logic [OCC_W-1:0]         reverse_count;

    modport source (output valid, func, push_value, reverse_count, input ready);
    modport sink   (input valid, func, push_value, reverse_count, output ready);
endinterface

interface fwpr_res_if;
    import fwpr_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] pop_value;
    logic [STAT_W-1:0]        status;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, pop_value, status, occupancy, input ready);
    modport sink   (input valid, pop_value, status, occupancy, output ready);
endinterface

@@ rtl/fifo_with_prefix_reverse_core.sv @@
// top level of the prefix-reverse queue: sequencer plus entry memory
// depends on fwpr_pkg, fwpr_if, fwpr_ram and fwpr_ctrl
//
//   channel | direction | handshake     | payload
//   cmd     | in        | valid / ready | func, push_value, reverse_count
//   res     | out       | valid / ready | pop_value, status, occupancy
//
// one request in flight; a finished result waits in an output register and
// the next request is taken in the same cycle that result is taken
// enqueue, refused and no-op results are registered when taken; a dequeue
// waits for the registered memory read; reverse of k entries: floor(k / 2)
// swaps, each of two reads and two writes on the single memory port pair
// reset clears pointers and count; memory content needs no clearing pass
`timescale 1ns / 1ps

module fifo_with_prefix_reverse_core (
    input  logic        clk,
    input  logic        rst_n,
    fwpr_cmd_if.sink    cmd,
    fwpr_res_if.source  res
);
    import fwpr_pkg::*;

    ram_req_t          ram_req;
    logic [WORD_W-1:0] ram_rdata;

    // sequencer
    fwpr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .res     (res),
        .ram_req (ram_req),
        .rdata   (ram_rdata)
    );

    // entry storage
    fwpr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

@@ rtl/fwpr_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module fwpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/fwpr_ctrl.sv @@
// queue sequencer: pointers, swap walk for prefix reverse, result register
// depends on fwpr_pkg and fwpr_if; drives the entry memory through ram_req_t
`timescale 1ns / 1ps

module fwpr_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    fwpr_cmd_if.sink                  cmd,
    fwpr_res_if.source                res,
    output fwpr_pkg::ram_req_t        ram_req,
    input  logic [fwpr_pkg::WORD_W-1:0] rdata
);
    import fwpr_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_POP  = 6'b000010,
        S_RD_A = 6'b000100,
        S_RD_B = 6'b001000,
        S_WR_A = 6'b010000,
        S_WR_B = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     lo_reg, lo_next;
    logic [AW-1:0]     hi_reg, hi_next;
    logic [WORD_W-1:0] tmp_reg, tmp_next;

    logic                     out_valid_reg, out_valid_next;
    logic signed [WORD_W-1:0] out_pop_reg;
    logic [STAT_W-1:0]        out_status_reg;
    logic [OCC_W-1:0]         out_occ_reg;

    logic                     out_load;
    logic signed [WORD_W-1:0] out_pop;
    logic [STAT_W-1:0]        out_status;
    logic [CW-1:0]            out_occ;

    logic          cmd_fire;
    logic [CW-1:0] k_eff;
    logic [AW-1:0] addr_lo;
    logic [AW-1:0] addr_hi;
    logic          more_pairs;

    // circular position of an offset from the head
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    // handshake: one request at a time, result slot free or draining
    assign cmd.ready = (state_reg == S_IDLE) && (!out_valid_reg || res.ready);
    assign cmd_fire  = cmd.valid && cmd.ready;

    // clamp the prefix length to the fill level
    always_comb
    begin
        if (cmd.reverse_count > OCC_W'(count_reg))
        begin
            k_eff = count_reg;
        end
        else
        begin
            k_eff = CW'(cmd.reverse_count);
        end
    end

    assign addr_lo    = slot_of(head_reg, lo_reg);
    assign addr_hi    = slot_of(head_reg, hi_reg);
    assign more_pairs = ({1'b0, lo_reg} + (AW + 1)'(2)) < {1'b0, hi_reg};

    // sequencer next state, memory access and result load
    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        tmp_next   = tmp_reg;

        ram_req.we    = 1'b0;
        ram_req.waddr = addr_lo;
        ram_req.wdata = cmd.push_value;
        ram_req.raddr = head_reg;

        out_load   = 1'b0;
        out_pop    = '0;
        out_status = ST_OK;
        out_occ    = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    priority if (cmd.func == FN_ENQ)
                    begin
                        out_load = 1'b1;
                        if (count_reg == DEPTH_C)
                        begin
                            out_status = ST_FULL;
                        end
                        else
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = slot_of(head_reg, count_reg[AW-1:0]);
                            count_next    = count_reg + 1'b1;
                            out_occ       = count_reg + 1'b1;
                        end
                    end
                    else if (cmd.func == FN_DEQ)
                    begin
                        if (count_reg == '0)
                        begin
                            out_load   = 1'b1;
                            out_pop    = POP_NONE;
                            out_status = ST_EMPTY;
                        end
                        else
                        begin
                            // head word comes back from memory next cycle
                            ram_req.raddr = head_reg;
                            head_next     = slot_of(head_reg, AW'(1));
                            count_next    = count_reg - 1'b1;
                            state_next    = S_POP;
                        end
                    end
                    else if (cmd.func == FN_REV)
                    begin
                        if (k_eff > CW'(1))
                        begin
                            lo_next    = '0;
                            hi_next    = AW'(k_eff - 1'b1);
                            state_next = S_RD_A;
                        end
                        else
                        begin
                            out_load = 1'b1;
                        end
                    end
                    else
                    begin
                        // unused code: no operation
                        out_load = 1'b1;
                    end
                end
            end
            S_POP:
            begin
                out_load   = 1'b1;
                out_pop    = rdata;
                state_next = S_IDLE;
            end
            S_RD_A:
            begin
                ram_req.raddr = addr_lo;
                state_next    = S_RD_B;
            end
            S_RD_B:
            begin
                // low entry arrives while the high one is being read
                ram_req.raddr = addr_hi;
                tmp_next      = rdata;
                state_next    = S_WR_A;
            end
            S_WR_A:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_lo;
                ram_req.wdata = rdata;
                state_next    = S_WR_B;
            end
            S_WR_B:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = addr_hi;
                ram_req.wdata = tmp_reg;
                lo_next       = lo_reg + 1'b1;
                hi_next       = hi_reg - 1'b1;
                if (more_pairs)
                begin
                    state_next = S_RD_A;
                end
                else
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result register hand-off
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // walk offsets, swap holding word and result payload
    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        tmp_reg <= tmp_next;
        if (out_load)
        begin
            out_pop_reg    <= out_pop;
            out_status_reg <= out_status;
            out_occ_reg    <= OCC_W'(out_occ);
        end
    end

    assign res.valid     = out_valid_reg;
    assign res.pop_value = out_pop_reg;
    assign res.status    = out_status_reg;
    assign res.occupancy = out_occ_reg;

endmodule

@@ rtl/fwpr_checker.sv @@
// port-level checks of the prefix-reverse queue, bound to the top level
// depends on fwpr_pkg and fifo_with_prefix_reverse_core_assert.svh
`timescale 1ns / 1ps
`include "fifo_with_prefix_reverse_core_assert.svh"

module fwpr_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cmd_valid,
    input logic                          cmd_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [fwpr_pkg::WORD_W-1:0]   res_pop_value,
    input logic [fwpr_pkg::STAT_W-1:0]   res_status,
    input logic [fwpr_pkg::OCC_W-1:0]    res_occupancy
);
    import fwpr_pkg::*;

    // result held until taken
    `FWPR_ASSERT(a_res_hold, clk, rst_n, res_valid && !res_ready |=> res_valid, "result dropped before taken")

    // no new request while a result is stuck
    `FWPR_ASSERT_ALWAYS(a_no_take_when_blocked, clk, res_valid && !res_ready |-> !cmd_ready, "request taken while result blocked")

    // after a request either its result shows or the input stays closed
    `FWPR_ASSERT(a_one_in_flight, clk, rst_n, cmd_valid && cmd_ready |=> res_valid || !cmd_ready, "second request taken before result")

    // refused enqueue only at capacity
    `FWPR_ASSERT(a_full_at_depth, clk, rst_n, res_valid && res_status == ST_FULL |-> res_occupancy == OCC_W'(DEPTH), "full status below capacity")

    // empty status only on an empty queue with the marker word
    `FWPR_ASSERT(a_empty_marker, clk, rst_n, res_valid && res_status == ST_EMPTY |-> res_occupancy == '0 && res_pop_value == POP_NONE, "empty status with bad payload")

endmodule

bind fifo_with_prefix_reverse_core fwpr_checker u_fwpr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_pop_value (res.pop_value),
    .res_status    (res.status),
    .res_occupancy (res.occupancy)
);

@@ verif/fifo_with_prefix_reverse_core_tb.sv @@
// self-checking testbench for the prefix-reverse queue: directed and random requests,
// every result checked against a behavioural queue held in a small scoreboard class
// depends on fwpr_pkg, fwpr_if and the rtl of fifo_with_prefix_reverse_core
`timescale 1ns / 1ps

module fifo_with_prefix_reverse_core_tb;
    import fwpr_pkg::*;

    // unused selector, behaves as a no-op
    localparam logic [FUNC_W-1:0] FN_NOP = 2'd3;

    localparam int ITEM_TARGET  = 1640;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYCS  = 300;
    localparam int CYCLE_LIMIT  = 2_500_000;
    localparam int MAX_PRINTED  = 40;

    // one result as seen on the output channel
    typedef struct packed {
        logic signed [WORD_W-1:0] pop_value;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
    } queue_outcome_t;

    // behavioural queue plus the results it still waits for
    class prefix_queue_scoreboard;
        logic [WORD_W-1:0] entries [DEPTH];
        int                head;
        int                occupancy;
        int                errors;
        queue_outcome_t    awaited_outcomes [$];

        function new();
            head      = 0;
            occupancy = 0;
            errors    = 0;
        endfunction

        // applies one accepted request and queues the result it must give
        function void predict_outcome(input logic [FUNC_W-1:0] func,
                                      input logic [WORD_W-1:0] value,
                                      input logic [OCC_W-1:0]  count);
            queue_outcome_t    want;
            int                span;
            int                lo;
            int                hi;
            logic [WORD_W-1:0] held;
            want.pop_value = '0;
            want.status    = ST_OK;
            case (func)
                FN_ENQ:
                begin
                    if (occupancy >= DEPTH)
                        want.status = ST_FULL;
                    else
                    begin
                        entries[(head + occupancy) % DEPTH] = value;
                        occupancy++;
                    end
                end
                FN_DEQ:
                begin
                    if (occupancy == 0)
                    begin
                        want.pop_value = POP_NONE;
                        want.status    = ST_EMPTY;
                    end
                    else
                    begin
                        want.pop_value = entries[head];
                        head = (head + 1) % DEPTH;
                        occupancy--;
                    end
                end
                FN_REV:
                begin
                    // clamp to what is held, then swap inwards from both ends
                    span = (int'(count) > occupancy) ? occupancy : int'(count);
                    lo   = 0;
                    hi   = span - 1;
                    while (lo < hi)
                    begin
                        held = entries[(head + lo) % DEPTH];
                        entries[(head + lo) % DEPTH] = entries[(head + hi) % DEPTH];
                        entries[(head + hi) % DEPTH] = held;
                        lo++;
                        hi--;
                    end
                end
                default:
                begin
                end
            endcase
            want.occupancy = OCC_W'(occupancy);
            awaited_outcomes.push_back(want);
        endfunction

        task report(input string what);
            if (errors < MAX_PRINTED)
                $display("%0t ns: mismatch: %s", $time, what);
            errors++;
        endtask

        // compares one accepted result with the oldest one waiting
        task check_result(input queue_outcome_t got);
            queue_outcome_t want;
            if (awaited_outcomes.size() == 0)
            begin
                report($sformatf("result with none waiting: pop %0d status %0d occupancy %0d",
                                 got.pop_value, got.status, got.occupancy));
                return;
            end
            want = awaited_outcomes.pop_front();
            if (got.pop_value !== want.pop_value)
                report($sformatf("pop_value %0d, wanted %0d", got.pop_value, want.pop_value));
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.occupancy !== want.occupancy)
                report($sformatf("occupancy %0d, wanted %0d", got.occupancy, want.occupancy));
        endtask
    endclass

    logic clk;
    logic rst_n;

    fwpr_cmd_if cmd_ch ();
    fwpr_res_if res_ch ();

    fifo_with_prefix_reverse_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    prefix_queue_scoreboard sb = new();

    int requests_sent = 0;
    int burst_left    = 0;
    int holds_asked   = 0;
    int holds_served  = 0;
    int cycle_count   = 0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d results outstanding",
                         cycle_count, sb.awaited_outcomes.size());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // offers one request, notes it once taken, then keeps to the burst pattern
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [WORD_W-1:0] value,
                                input logic [OCC_W-1:0]  count);
        int gap;
        cmd_ch.valid         <= 1'b1;
        cmd_ch.func          <= func;
        cmd_ch.push_value    <= value;
        cmd_ch.reverse_count <= count;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.predict_outcome(func, value, count);
        requests_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 12);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(0, 20);
        end
    endtask

    // sender goes quiet until every result is back
    task automatic pause_until_drained();
        cmd_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.awaited_outcomes.size() != 0);
    endtask

    // one random request under a given operation mix
    task automatic offer_random(input int enq_pct, input int deq_pct);
        int                pick;
        logic [FUNC_W-1:0] func;
        logic [OCC_W-1:0]  count;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            func = FN_NOP;
        else if (pick < 3 + enq_pct)
            func = FN_ENQ;
        else if (pick < 3 + enq_pct + deq_pct)
            func = FN_DEQ;
        else
            func = FN_REV;
        // mostly short prefixes, some whole-queue and oversized ones
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: count = OCC_W'($urandom_range(0, 6));
            6:                count = OCC_W'(sb.occupancy);
            7:                count = OCC_W'($urandom_range(0, 255));
            8:                count = OCC_W'($urandom_range(128, 255));
            default:          count = OCC_W'($urandom_range(0, sb.occupancy));
        endcase
        send_request(func, $urandom, count);
    endtask

    // fills to capacity behind a long receiver hold, reverses the lot, drains it
    task automatic fill_and_empty();
        holds_asked++;
        while (sb.occupancy < DEPTH)
            send_request(FN_ENQ, $urandom, OCC_W'($urandom));
        send_request(FN_ENQ, $urandom, OCC_W'($urandom));
        send_request(FN_ENQ, $urandom, OCC_W'($urandom));
        send_request(FN_REV, $urandom, OCC_W'(DEPTH));
        send_request(FN_REV, $urandom, 8'd200);
        while (sb.occupancy > 0)
            offer_random(5, 85);
        send_request(FN_DEQ, $urandom, OCC_W'($urandom));
    endtask

    // result side: stall pattern, long hold on request, checking
    initial
    begin
        int             hold_left;
        int             mode;
        int             mode_left;
        queue_outcome_t got;
        hold_left    = 0;
        mode         = 0;
        mode_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (res_ch.valid && res_ch.ready)
                begin
                    got.pop_value = res_ch.pop_value;
                    got.status    = res_ch.status;
                    got.occupancy = res_ch.occupancy;
                    sb.check_result(got);
                end
                if (holds_asked != holds_served)
                begin
                    holds_served = holds_asked;
                    hold_left    = LONG_HOLD;
                end
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                if (hold_left > 0)
                begin
                    hold_left--;
                    res_ch.ready <= 1'b0;
                end
                else
                begin
                    case (mode)
                        0:       res_ch.ready <= 1'b1;
                        1:       res_ch.ready <= ($urandom_range(0, 1) == 0);
                        2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: res_ch.ready <= ((mode_left % 5) < 3);
                    endcase
                end
            end
        end
    end

    // reset, stimulus and end of run
    initial
    begin
        int mode;
        int phase_len;
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.func          = FN_ENQ;
        cmd_ch.push_value    = '0;
        cmd_ch.reverse_count = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-queue cases, extreme words, every reverse length class
        send_request(FN_DEQ, 32'h0000_0000, 8'd0);
        send_request(FN_REV, 32'h0000_0000, 8'd5);
        send_request(FN_NOP, 32'hFFFF_FFFF, 8'hFF);
        send_request(FN_ENQ, 32'h7FFF_FFFF, 8'h00);
        send_request(FN_ENQ, 32'h8000_0000, 8'hFF);
        send_request(FN_ENQ, 32'hFFFF_FFFF, 8'h00);
        send_request(FN_ENQ, 32'h0000_0000, 8'hFF);
        send_request(FN_ENQ, 32'h5555_AAAA, 8'h00);
        send_request(FN_REV, 32'h0000_0000, 8'd0);
        send_request(FN_REV, 32'h0000_0000, 8'd1);
        send_request(FN_REV, 32'h0000_0000, 8'd2);
        send_request(FN_REV, 32'h0000_0000, 8'd3);
        send_request(FN_REV, 32'hFFFF_FFFF, 8'd255);
        send_request(FN_ENQ, 32'hAAAA_5555, 8'd0);
        send_request(FN_REV, 32'h0000_0000, 8'd6);
        send_request(FN_REV, 32'h0000_0000, 8'h80);
        send_request(FN_NOP, 32'h0000_0000, 8'h00);
        repeat (6) send_request(FN_DEQ, 32'hFFFF_FFFF, 8'hFF);
        send_request(FN_DEQ, 32'h0000_0000, 8'd0);
        pause_until_drained();

        // full queue with wrapped head, stalled input behind the long hold
        fill_and_empty();
        pause_until_drained();

        // random phases: filling, draining or balanced mixes
        while (requests_sent < ITEM_TARGET)
        begin
            mode      = $urandom_range(0, 2);
            phase_len = $urandom_range(80, 250);
            repeat (phase_len)
            begin
                case (mode)
                    0:       offer_random(75, 10);
                    1:       offer_random(10, 75);
                    default: offer_random(40, 40);
                endcase
            end
            if ($urandom_range(0, 2) == 0)
                pause_until_drained();
        end
        fill_and_empty();

        // let everything come back, then watch for strays
        pause_until_drained();
        repeat (SETTLE_CYCS) @(posedge clk);
        if (sb.awaited_outcomes.size() != 0)
            sb.report($sformatf("%0d results never came", sb.awaited_outcomes.size()));
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/fwpr_pkg.sv
rtl/fwpr_if.sv
rtl/fwpr_ram.sv
rtl/fwpr_ctrl.sv
rtl/fifo_with_prefix_reverse_core.sv
rtl/fwpr_checker.sv
verif/fifo_with_prefix_reverse_core_tb.sv
